// ===== rtl/lpg_pkg.sv =====
package lpg_pkg;

	// Width of the colour value carried from each request to each of its pixels.
	localparam int COLOUR_BITS = 32;

	// Sequencer states.
	typedef enum logic [1:0] {
		LPG_IDLE,
		LPG_SPAN,
		LPG_ORDER,
		LPG_RUN
	} lpg_state_t;

endpackage

// ===== rtl/lpg_req_if.sv =====
interface lpg_req_if import lpg_pkg::*; #(
	parameter int COORD_BITS = 6
) ();

	logic                   valid;
	logic                   ready;
	logic [COORD_BITS-1:0]  start_x;
	logic [COORD_BITS-1:0]  start_y;
	logic [COORD_BITS-1:0]  end_x;
	logic [COORD_BITS-1:0]  end_y;
	logic [COLOUR_BITS-1:0] colour;

	modport source (output valid, start_x, start_y, end_x, end_y, colour, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, colour, output ready);

endinterface

// ===== rtl/lpg_pix_if.sv =====
interface lpg_pix_if import lpg_pkg::*; #(
	parameter int COORD_BITS = 6
) ();

	logic                   valid;
	logic                   ready;
	logic [COORD_BITS-1:0]  pixel_x;
	logic [COORD_BITS-1:0]  pixel_y;
	logic [COLOUR_BITS-1:0] pixel_colour;
	logic                   last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_colour, last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_colour, last_pixel, output ready);

endinterface

// ===== rtl/line_pixel_generator.sv =====
// Integer error-term line rasteriser. One request item carries two endpoints and
// a colour; the block answers with one pixel item for every pixel of the line,
// ordered so that the major coordinate rises, each tagged with the colour and with
// last_pixel set on the final one. A request is taken only while the block is
// idle. It then passes through the set-up states LPG_SPAN (absolute spans) and
// LPG_ORDER (axis choice and endpoint ordering) and afterwards emits one pixel
// per cycle through the registered output while that register is empty or the
// pixel sink holds ready high. The pixel rate is set by the single error-term
// update unit, which is used once per pixel. The final pixel of a line may still
// wait in the output register while the next request is accepted.
module line_pixel_generator import lpg_pkg::*; #(
	parameter int COORD_BITS = 6
) (
	input logic    clk,
	input logic    arst_n,
	lpg_req_if.sink   req,
	lpg_pix_if.source pix
);

	lpg_state_t state_q, state_d;

	// Request held for the whole line.
	logic [COORD_BITS-1:0]  ax_q, ay_q, bx_q, by_q;
	logic [COLOUR_BITS-1:0] colour_q;

	// Absolute spans, registered in the LPG_SPAN state.
	logic [COORD_BITS-1:0] dx_q, dy_q;

	// Walking state.
	logic                         steep_q;
	logic                         dir_up_q;
	logic [COORD_BITS-1:0]        maj_q, maj1_q, min_q;
	logic [COORD_BITS-1:0]        dmaj_q, dmin_q;
	logic signed [COORD_BITS:0]   err_q;

	// Output register.
	logic                   pix_valid_q;
	logic [COORD_BITS-1:0]  pix_x_q, pix_y_q;
	logic [COLOUR_BITS-1:0] pix_colour_q;
	logic                   pix_last_q;

	// Control.
	logic accept_c;
	logic emit_c;
	logic last_c;

	// Axis choice and ordering, worked out during the LPG_ORDER state.
	logic                  steep_c;
	logic                  swap_c;
	logic [COORD_BITS-1:0] a_maj_c, a_min_c, b_maj_c, b_min_c;
	logic [COORD_BITS-1:0] maj0_c, min0_c, maj1_c, min1_c;

	logic signed [COORD_BITS:0] err_next;
	logic [COORD_BITS-1:0]      min_next;

	lpg_step_unit #(
		.COORD_BITS (COORD_BITS)
	) u_step (
		.err        (err_q),
		.dmaj       (dmaj_q),
		.dmin       (dmin_q),
		.minor      (min_q),
		.dir_up     (dir_up_q),
		.err_next   (err_next),
		.minor_next (min_next)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			LPG_IDLE: begin
				if (req.valid) state_d = LPG_SPAN;
			end
			LPG_SPAN:  state_d = LPG_ORDER;
			LPG_ORDER: state_d = LPG_RUN;
			LPG_RUN: begin
				if (emit_c && last_c) state_d = LPG_IDLE;
			end
			default: state_d = LPG_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		last_c    = (maj_q == maj1_q);
		req.ready = (state_q == LPG_IDLE);
		accept_c  = (state_q == LPG_IDLE) && req.valid;
		// A pixel moves into the output register when that register is empty
		// or is being emptied in this cycle.
		emit_c    = (state_q == LPG_RUN) && (!pix_valid_q || pix.ready);
	end

	// A steep line walks along y; on equal spans x stays the major axis.
	always_comb begin
		steep_c = (dy_q > dx_q);
		a_maj_c = steep_c ? ay_q : ax_q;
		a_min_c = steep_c ? ax_q : ay_q;
		b_maj_c = steep_c ? by_q : bx_q;
		b_min_c = steep_c ? bx_q : by_q;
		swap_c  = (a_maj_c > b_maj_c);
		maj0_c  = swap_c ? b_maj_c : a_maj_c;
		min0_c  = swap_c ? b_min_c : a_min_c;
		maj1_c  = swap_c ? a_maj_c : b_maj_c;
		min1_c  = swap_c ? a_min_c : b_min_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= LPG_IDLE;
			pix_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_c) begin
				pix_valid_q <= 1'b1;
			end else if (pix.ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_c) begin
			ax_q     <= req.start_x;
			ay_q     <= req.start_y;
			bx_q     <= req.end_x;
			by_q     <= req.end_y;
			colour_q <= req.colour;
		end
		if (state_q == LPG_SPAN) begin
			dx_q <= (bx_q >= ax_q) ? bx_q - ax_q : ax_q - bx_q;
			dy_q <= (by_q >= ay_q) ? by_q - ay_q : ay_q - by_q;
		end
		if (state_q == LPG_ORDER) begin
			steep_q  <= steep_c;
			maj_q    <= maj0_c;
			maj1_q   <= maj1_c;
			min_q    <= min0_c;
			dir_up_q <= (min0_c < min1_c);
			dmaj_q   <= steep_c ? dy_q : dx_q;
			dmin_q   <= steep_c ? dx_q : dy_q;
			// The error term starts at half the major span, rounded down.
			err_q    <= $signed({2'b00,
				(steep_c ? dy_q[COORD_BITS-1:1] : dx_q[COORD_BITS-1:1])});
		end
		if (emit_c) begin
			pix_x_q      <= steep_q ? min_q : maj_q;
			pix_y_q      <= steep_q ? maj_q : min_q;
			pix_colour_q <= colour_q;
			pix_last_q   <= last_c;
			maj_q        <= maj_q + 1'b1;
			min_q        <= min_next;
			err_q        <= err_next;
		end
	end

	assign pix.valid        = pix_valid_q;
	assign pix.pixel_x      = pix_x_q;
	assign pix.pixel_y      = pix_y_q;
	assign pix.pixel_colour = pix_colour_q;
	assign pix.last_pixel   = pix_last_q;

	// The walk never passes the far endpoint.
	a_run_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == LPG_RUN) |-> (maj_q <= maj1_q))
		else $error("major coordinate passed the far endpoint");

	// The error term stays non-negative between pixels.
	a_err_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == LPG_RUN) |-> !err_q[COORD_BITS])
		else $error("error term negative while walking");

	// Emitting the final pixel ends the line.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_c && last_c) |=> (state_q == LPG_IDLE && pix_valid_q && pix_last_q))
		else $error("line did not end on its final pixel");

	// An accepted request starts the set-up sequence.
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		accept_c |=> (state_q == LPG_SPAN))
		else $error("accepted request did not start set-up");

endmodule

// ===== rtl/lpg_step_unit.sv =====
// Error-term update shared by every step along the major axis.
module lpg_step_unit import lpg_pkg::*; #(
	parameter int COORD_BITS = 6
) (
	input  logic signed [COORD_BITS:0]   err,
	input  logic        [COORD_BITS-1:0] dmaj,
	input  logic        [COORD_BITS-1:0] dmin,
	input  logic        [COORD_BITS-1:0] minor,
	input  logic                         dir_up,
	output logic signed [COORD_BITS:0]   err_next,
	output logic        [COORD_BITS-1:0] minor_next
);

	logic signed [COORD_BITS:0] diff;

	always_comb begin
		diff = err - $signed({1'b0, dmin});
		if (diff[COORD_BITS]) begin
			err_next   = diff + $signed({1'b0, dmaj});
			minor_next = dir_up ? minor + 1'b1 : minor - 1'b1;
		end else begin
			err_next   = diff;
			minor_next = minor;
		end
	end

endmodule

// ===== tb/sv/tb_line_pixel_generator.sv =====
`timescale 1ns / 1ps

module tb_line_pixel_generator;
	import lpg_pkg::*;

	localparam int COORD_BITS = 6;
	localparam int RAND_LINES = 310;
	// Drain wait after the last expected pixel, sized from the raster width.
	localparam int DRAIN_CYCLES = (1 << COORD_BITS) + 8;
	localparam int HOLD_CYCLES = 400;

	typedef logic [COORD_BITS-1:0] coord_t;

	// One line request as it crosses the request channel.
	typedef struct packed {
		coord_t                 start_x;
		coord_t                 start_y;
		coord_t                 end_x;
		coord_t                 end_y;
		logic [COLOUR_BITS-1:0] colour;
	} line_req_t;

	// One pixel as it crosses the pixel channel.
	typedef struct packed {
		coord_t                 pixel_x;
		coord_t                 pixel_y;
		logic [COLOUR_BITS-1:0] pixel_colour;
		logic                   last_pixel;
	} pixel_t;

	// The scoreboard walks each accepted line itself and keeps the pixels it
	// expects in order; every pixel that leaves the block is checked against
	// the oldest one still waiting.
	class line_scoreboard;
		pixel_t pixels_due[$];
		int     errors;

		function new();
			errors = 0;
		endfunction

		// Integer line walk: pick the major axis, order the endpoints so that the
		// major coordinate rises, then step the minor coordinate whenever the
		// error term drops below zero.
		function void note_request(line_req_t r);
			int     ax, ay, bx, by;
			int     maj0, min0, maj1, min1, tmp;
			int     dmaj, dmin, err, step;
			bit     steep;
			pixel_t p;
			ax = r.start_x;
			ay = r.start_y;
			bx = r.end_x;
			by = r.end_y;
			steep = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
			if (steep) begin
				maj0 = ay; min0 = ax; maj1 = by; min1 = bx;
			end else begin
				maj0 = ax; min0 = ay; maj1 = bx; min1 = by;
			end
			if (maj0 > maj1) begin
				tmp = maj0; maj0 = maj1; maj1 = tmp;
				tmp = min0; min0 = min1; min1 = tmp;
			end
			dmaj = maj1 - maj0;
			dmin = (min1 > min0) ? min1 - min0 : min0 - min1;
			err = dmaj / 2;
			step = (min0 < min1) ? 1 : -1;
			for (; maj0 <= maj1; maj0++) begin
				p.pixel_x = steep ? coord_t'(min0) : coord_t'(maj0);
				p.pixel_y = steep ? coord_t'(maj0) : coord_t'(min0);
				p.pixel_colour = r.colour;
				p.last_pixel = (maj0 == maj1);
				pixels_due.push_back(p);
				err -= dmin;
				if (err < 0) begin
					min0 += step;
					err += dmaj;
				end
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (pixels_due.size() == 0) begin
				errors++;
				$display("%0t: pixel with none expected: x=%0d y=%0d colour=%h last=%0b",
					$time, got.pixel_x, got.pixel_y, got.pixel_colour, got.last_pixel);
				return;
			end
			want = pixels_due.pop_front();
			if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
					got.pixel_colour !== want.pixel_colour ||
					got.last_pixel !== want.last_pixel) begin
				errors++;
				$display("%0t: expected %0d,%0d %h %0b, got %0d,%0d %h %0b",
					$time, want.pixel_x, want.pixel_y, want.pixel_colour, want.last_pixel,
					got.pixel_x, got.pixel_y, got.pixel_colour, got.last_pixel);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lpg_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
	lpg_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();

	line_pixel_generator #(.COORD_BITS(COORD_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.pix    (pix_ch)
	);

	line_scoreboard sb;

	// When set, both the request source and the pixel sink idle at random;
	// the main sequence clears it for one stretch of back-to-back traffic.
	bit idle_on;
	int lines_accepted;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Every input of the block is at a known value from time zero.
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.start_x = '0;
		req_ch.start_y = '0;
		req_ch.end_x = '0;
		req_ch.end_y = '0;
		req_ch.colour = '0;
		pix_ch.ready = 1'b0;
	end

	// Both channels are observed at the rising edge. A request is noted before
	// any pixel of the same edge is checked, although a line can never produce
	// a pixel on the edge at which it is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				sb.note_request({req_ch.start_x, req_ch.start_y, req_ch.end_x,
					req_ch.end_y, req_ch.colour});
				lines_accepted++;
			end
			if (pix_ch.valid && pix_ch.ready)
				sb.check_pixel({pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.pixel_colour,
					pix_ch.last_pixel});
		end
	end

	// Pixel sink. Ready changes only at the falling edge. Once some lines have
	// gone through, the sink holds ready low for a long stretch so that the
	// block fills up and refuses further requests while they are on offer.
	initial begin : pixel_sink
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && lines_accepted >= 40) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_ch.ready <= 1'b0;
			end else begin
				pix_ch.ready <= !(idle_on && $urandom_range(0, 99) < 32);
			end
		end
	end

	// Offers one line, after a random number of idle cycles while idle_on is set,
	// and returns once it has been accepted. Valid stays high on return, so a
	// following call that adds no gap presents its item on the very next cycle.
	task automatic send_line(input line_req_t r);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 32) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.start_x <= r.start_x;
		req_ch.start_y <= r.start_y;
		req_ch.end_x <= r.end_x;
		req_ch.end_y <= r.end_y;
		req_ch.colour <= r.colour;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Random line. Most are fully random across the raster; some are short
	// lines around a random point, and some collapse to a single point, so
	// that short runs and back-to-back requests are common too.
	function automatic line_req_t random_line();
		line_req_t r;
		int        kind;
		kind = $urandom_range(0, 7);
		r.start_x = coord_t'($urandom);
		r.start_y = coord_t'($urandom);
		r.colour = $urandom;
		if (kind == 0) begin
			r.end_x = r.start_x;
			r.end_y = r.start_y;
		end else if (kind <= 2) begin
			r.end_x = r.start_x + coord_t'($urandom_range(0, 6)) - coord_t'(3);
			r.end_y = r.start_y + coord_t'($urandom_range(0, 6)) - coord_t'(3);
		end else begin
			r.end_x = coord_t'($urandom);
			r.end_y = coord_t'($urandom);
		end
		return r;
	endfunction

	initial begin : main_sequence
		line_req_t directed[$];
		localparam coord_t CMAX = '1;
		sb = new();
		idle_on = 1'b1;
		lines_accepted = 0;

		// Directed lines: single points at both corners, full-length horizontal
		// and vertical lines in both directions, equal-span diagonals (which
		// keep x as the major axis), shallow and steep lines whose minor
		// coordinate falls, and colours that set every bit both ways.
		directed.push_back('{6'd0, 6'd0, 6'd0, 6'd0, 32'h0000_0000});
		directed.push_back('{CMAX, CMAX, CMAX, CMAX, 32'hFFFF_FFFF});
		directed.push_back('{6'd0, 6'd0, CMAX, 6'd0, 32'hAAAA_AAAA});
		directed.push_back('{CMAX, 6'd5, 6'd0, 6'd5, 32'h5555_5555});
		directed.push_back('{6'd0, 6'd0, 6'd0, CMAX, 32'h0123_4567});
		directed.push_back('{6'd9, CMAX, 6'd9, 6'd0, 32'h89AB_CDEF});
		directed.push_back('{6'd0, 6'd0, CMAX, CMAX, 32'hFFFF_0000});
		directed.push_back('{CMAX, CMAX, 6'd0, 6'd0, 32'h0000_FFFF});
		directed.push_back('{6'd0, CMAX, CMAX, 6'd0, 32'hF0F0_F0F0});
		directed.push_back('{CMAX, 6'd0, 6'd0, CMAX, 32'h0F0F_0F0F});
		directed.push_back('{6'd2, 6'd3, 6'd7, 6'd7, 32'h1111_1111});
		directed.push_back('{6'd2, 6'd3, 6'd7, 6'd8, 32'h2222_2222});
		directed.push_back('{6'd0, 6'd40, CMAX, 6'd30, 32'h3333_3333});
		directed.push_back('{6'd50, 6'd0, 6'd41, CMAX, 32'h4444_4444});
		directed.push_back('{6'd20, 6'd20, 6'd21, 6'd21, 32'hDEAD_BEEF});
		directed.push_back('{6'd20, 6'd20, 6'd21, 6'd20, 32'hCAFE_F00D});
		directed.push_back('{6'd20, 6'd20, 6'd20, 6'd19, 32'h8000_0001});
		directed.push_back('{6'd1, 6'd62, 6'd62, 6'd1, 32'h7FFF_FFFE});
		directed.push_back('{6'd42, 6'd21, 6'd21, 6'd42, 32'hA5A5_5A5A});
		directed.push_back('{6'd0, 6'd63, 6'd3, 6'd0, 32'h5A5A_A5A5});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_line(directed[i]);

		// Random lines in three stretches: idling on, then a stretch of
		// back-to-back traffic on both sides, then idling on again.
		for (int i = 0; i < RAND_LINES; i++) begin
			if (i == 120)
				idle_on = 1'b0;
			else if (i == 200)
				idle_on = 1'b1;
			send_line(random_line());
		end
		@(negedge clk);
		req_ch.valid <= 1'b0;

		while (sb.pixels_due.size() != 0)
			@(posedge clk);
		// Give the block time to show any pixel it should not produce.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.pixels_due.size() != 0) begin
			sb.errors++;
			$display("%0t: %0d expected pixels never arrived", $time, sb.pixels_due.size());
		end
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Far beyond the slowest correct run, even with every pixel stalled.
	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lpg_pkg.sv
rtl/lpg_req_if.sv
rtl/lpg_pix_if.sv
rtl/lpg_step_unit.sv
rtl/line_pixel_generator.sv
tb/sv/tb_line_pixel_generator.sv
